>>> sv/itce_pkg.sv
`default_nettype none

package itce_pkg;

    // Packet modes, taken from cmd on the first word of a packet
    localparam logic [1:0] MODE_IPV4_HDR = 2'd0;
    localparam logic [1:0] MODE_TCP_V4   = 2'd1;
    localparam logic [1:0] MODE_TCP_V6   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SHORT      = 2'd1;
    localparam logic [1:0] ST_BAD_LEN    = 2'd2;

    localparam logic [4:0]  V6_HDR_WORDS = 5'd20;
    localparam logic [15:0] TCP_NEXT_HDR = 16'd6;
    localparam logic [3:0]  IHL_MIN      = 4'd5;

    // Word positions inside the IP headers
    localparam logic [15:0] IX_V4_TOTLEN  = 16'd1;
    localparam logic [15:0] IX_V4_PROTO   = 16'd4;
    localparam logic [15:0] IX_V4_SRC     = 16'd6;
    localparam logic [15:0] IX_V4_DST_END = 16'd9;
    localparam logic [15:0] IX_V6_PAYLEN  = 16'd2;
    localparam logic [15:0] IX_V6_SRC     = 16'd4;
    localparam logic [15:0] IX_V6_DST_END = 16'd19;
    localparam logic [15:0] IX_MAX        = 16'hFFFF;

    // Ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/ip_tcp_checksum_engine.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_cmd, i_data_word, i_last
// result    out        o_out_valid / i_out_stall  o_checksum, o_status
//
// One packet word a cycle: each transfer lands in an input register, and one
// ones-complement add with the length compares turns it into accumulator state
// and, on the last word, a result in the output register. Input stalls only when
// a last word finds the result register still full and held. Reset (synchronous,
// active low) clears the packet state and both valids.

module ip_tcp_checksum_engine import itce_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_checksum,
    output logic [1:0]       o_status
);

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic [15:0] r_in_word;
    logic        r_in_last;

    // Packet state
    logic [15:0] r_idx, n_idx;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_mode, n_mode;
    logic [4:0]  r_hw, n_hw;
    logic [15:0] r_decl, n_decl;
    logic        r_bad, n_bad;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_checksum, n_checksum;
    logic [1:0]  r_status, n_status;

    logic        advance;
    logic        in_accept;
    logic        first;
    logic [3:0]  ihl;
    logic [15:0] hw_bytes;
    logic [15:0] region_end;
    logic [15:0] region_start;
    logic [15:0] half_decl;
    logic [16:0] seen;
    logic [15:0] need;
    logic        in_region;
    logic        odd_tail;
    logic [15:0] operand;
    logic        add_en;

    // Hold the word while a last word cannot hand its result over
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        first = (r_idx == 16'd0);
        ihl   = r_in_word[11:8];

        // Mode and header size are fixed on the first word
        if (first) begin
            n_mode = (r_in_cmd == MODE_UNUSED) ? MODE_IPV4_HDR : r_in_cmd;
        end else begin
            n_mode = r_mode;
        end
        if (first) begin
            n_hw = (n_mode == MODE_TCP_V6) ? V6_HDR_WORDS : {ihl, 1'b0};
        end else begin
            n_hw = r_hw;
        end
        hw_bytes = {10'd0, n_hw, 1'b0};

        n_decl = r_decl;
        if ((n_mode == MODE_TCP_V4 && r_idx == IX_V4_TOTLEN) ||
            (n_mode == MODE_TCP_V6 && r_idx == IX_V6_PAYLEN)) begin
            n_decl = r_in_word;
        end

        n_bad = r_bad;
        if (first && n_mode != MODE_TCP_V6 && ihl < IHL_MIN) begin
            n_bad = 1'b1;
        end
        if (n_mode == MODE_TCP_V4 && r_idx == IX_V4_TOTLEN && r_in_word < hw_bytes) begin
            n_bad = 1'b1;
        end

        // Exclusive end of the summed region, in words
        half_decl = {1'b0, n_decl[15:1]} + {15'd0, n_decl[0]};
        case (n_mode)
            MODE_TCP_V4: region_end = half_decl;
            MODE_TCP_V6: region_end = half_decl + {11'd0, V6_HDR_WORDS};
            default:     region_end = {11'd0, n_hw};
        endcase
        region_start = (n_mode == MODE_IPV4_HDR) ? 16'd0 : {11'd0, n_hw};
        seen      = {1'b0, r_idx} + 17'd1;
        in_region = (r_idx >= region_start) && (r_idx < region_end);
        odd_tail  = (n_mode != MODE_IPV4_HDR) && n_decl[0] &&
                    (seen == {1'b0, region_end});

        // One add a word; the pseudo-header terms go in as soon as they are known,
        // which ones-complement addition allows in any order
        add_en  = 1'b1;
        operand = r_in_word;
        if (in_region) begin
            operand = odd_tail ? {r_in_word[15:8], 8'd0} : r_in_word;
        end else if (n_mode == MODE_TCP_V4) begin
            if (r_idx == IX_V4_TOTLEN) begin
                operand = r_in_word - hw_bytes;
            end else if (r_idx == IX_V4_PROTO) begin
                operand = {8'd0, r_in_word[7:0]};
            end else begin
                add_en = (r_idx >= IX_V4_SRC) && (r_idx <= IX_V4_DST_END);
            end
        end else if (n_mode == MODE_TCP_V6) begin
            if (first) begin
                operand = TCP_NEXT_HDR;
            end else begin
                add_en = (r_idx == IX_V6_PAYLEN) ||
                         ((r_idx >= IX_V6_SRC) && (r_idx <= IX_V6_DST_END));
            end
        end else begin
            add_en = 1'b0;
        end
        n_acc = add_en ? oc_add(r_acc, operand) : r_acc;

        n_idx = (r_idx != IX_MAX) ? r_idx + 16'd1 : r_idx;

        // Result for the last word; a bad length outranks a short packet
        need = (region_end > {11'd0, n_hw}) ? region_end : {11'd0, n_hw};
        if (n_bad) begin
            n_status = ST_BAD_LEN;
        end else if ((seen < {1'b0, need}) ||
                     (n_mode == MODE_TCP_V4 && seen < 17'd2) ||
                     (n_mode == MODE_TCP_V6 && seen < 17'd3)) begin
            n_status = ST_SHORT;
        end else begin
            n_status = ST_OK;
        end
        n_checksum = (n_status == ST_OK) ? ~n_acc : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd  <= i_cmd;
            r_in_word <= i_data_word;
            r_in_last <= i_last;
        end
    end

    // Advance the packet state; rearm on the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 16'd0;
            r_acc  <= 16'd0;
            r_mode <= MODE_IPV4_HDR;
            r_hw   <= 5'd0;
            r_decl <= 16'd0;
            r_bad  <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_idx  <= 16'd0;
                r_acc  <= 16'd0;
                r_mode <= MODE_IPV4_HDR;
                r_hw   <= 5'd0;
                r_decl <= 16'd0;
                r_bad  <= 1'b0;
            end else begin
                r_idx  <= n_idx;
                r_acc  <= n_acc;
                r_mode <= n_mode;
                r_hw   <= n_hw;
                r_decl <= n_decl;
                r_bad  <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_checksum <= n_checksum;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;
    assign o_status    = r_status;

endmodule

`default_nettype wire

>>> sv/itce_chk.sv
`default_nettype none

module itce_chk import itce_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_checksum,
    input wire logic [1:0]  o_status
);

    // A held result keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_checksum) && $stable(o_status))
        else $error("result changed while held");

    // Only a full, held result register may push back on the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with result side free");

    // A failed packet carries a zero checksum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_checksum == 16'd0)
        else $error("checksum not zero on error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_SHORT || o_status == ST_BAD_LEN)
        else $error("undefined status code");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ip_tcp_checksum_engine itce_chk u_itce_chk (.*);

`default_nettype wire
